FILE: hdl/pdwq_pkg.sv
`timescale 1ns / 1ps
package pdwq_pkg;

  typedef logic [2:0] func_t;
  typedef logic [7:0] byte_t;
  typedef logic [2:0] init_step_t;
  typedef logic [1:0] cfg_index_t;

  localparam func_t FUNC_DATA    = 3'd0;
  localparam func_t FUNC_COMMAND = 3'd1;
  localparam func_t FUNC_START   = 3'd2;
  localparam func_t FUNC_TICK    = 3'd3;
  localparam func_t FUNC_INIT    = 3'd4;

  localparam cfg_index_t CFG_DATA_GAP     = 2'd0;
  localparam cfg_index_t CFG_COMMAND_GAP  = 2'd1;
  localparam cfg_index_t CFG_POWERUP_WAIT = 2'd2;

  localparam byte_t DATA_GAP_RESET     = 8'd0;
  localparam byte_t COMMAND_GAP_RESET  = 8'd4;
  localparam byte_t POWERUP_WAIT_RESET = 8'd15;

  // The init sequence is six command bytes long.
  localparam int         INIT_LEN  = 6;
  localparam init_step_t INIT_LAST = 3'(INIT_LEN - 1);

  localparam byte_t CMD_FUNCTION_SET = 8'h38;
  localparam byte_t CMD_ENTRY_MODE   = 8'h06;
  localparam byte_t CMD_DISPLAY_ON   = 8'h0E;
  localparam byte_t CMD_CLEAR        = 8'h01;

  typedef struct packed {
    logic       bus_write;
    byte_t      bus_byte;
    logic       register_select;
    logic       accepted;
    logic       busy_res;
  } out_res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       in_ready;
    logic       commit;
    logic       init_wr;
    init_step_t init_step;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_valid;
    logic is_init;
    logic out_free;
  } dp_status_t;

  function automatic byte_t init_cmd(init_step_t step);
    byte_t b;
    case (step)
      3'd0, 3'd1, 3'd2: b = CMD_FUNCTION_SET;
      3'd3:             b = CMD_ENTRY_MODE;
      3'd4:             b = CMD_DISPLAY_ON;
      3'd5:             b = CMD_CLEAR;
      default:          b = CMD_CLEAR;
    endcase
    return b;
  endfunction

endpackage

FILE: hdl/pdwq_ifs.sv
`timescale 1ns / 1ps
interface pdwq_in_if;
  logic            valid;
  logic            ready;
  pdwq_pkg::func_t func;
  pdwq_pkg::byte_t entry_byte;
  modport source(output valid, func, entry_byte, input ready);
  modport sink(input valid, func, entry_byte, output ready);
endinterface

interface pdwq_out_if;
  logic            valid;
  logic            ready;
  logic            bus_write;
  pdwq_pkg::byte_t bus_byte;
  logic            register_select;
  logic            accepted;
  logic            busy_res;
  modport source(output valid, bus_write, bus_byte, register_select, accepted, busy_res,
                 input ready);
  modport sink(input valid, bus_write, bus_byte, register_select, accepted, busy_res,
               output ready);
endinterface

interface pdwq_cfg_if;
  logic                 valid;
  logic                 ready;
  pdwq_pkg::cfg_index_t index;
  pdwq_pkg::byte_t      data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

FILE: hdl/paced_display_write_queue.sv
`timescale 1ns / 1ps
// Paced write queue for a character display.
// in_ch carries one item per handshake: func selects queue data, queue command,
// start, tick or init, and entry_byte is the byte to queue. cfg_ch writes the
// data gap, command gap and power-up wait registers; it is always ready and
// should only be used while the queue is idle. out_ch returns exactly one
// result item for every input item: the bus strobe, byte and register select
// for this tick, whether a put was accepted, and whether draining continues.
// Each item is captured on acceptance and committed once the output is free;
// an init item first passes through the init steps, which write the six
// init commands into the entry memory one per cycle. Items are processed one
// at a time, so a new item is taken only after the previous one has committed.
// A tick reads the memory through a registered read port addressed by the
// read position, which is why the controller has an execute state between
// accept and commit. The finished result sits in an output register; if the
// receiver stalls, the block accepts one more item and then holds it until
// the register frees. After reset the queue is empty, idle, with no wait
// pending, and the registers hold gaps of 0 and 4 and a wait of 15 ticks.
module paced_display_write_queue #(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  pdwq_in_if.sink    in_ch,
  pdwq_out_if.source out_ch,
  pdwq_cfg_if.sink   cfg_ch
);
  import pdwq_pkg::*;

  // Commands and status between the sequencing controller and the datapath.
  ctrl_cmd_t  cmd;
  dp_status_t status;

  // The controller walks each item through accept, commit and, for init,
  // the six-step write of the start-up command sequence.
  pdwq_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .cmd    (cmd)
  );

  // The datapath holds the entry memory, the counters, the wait timer, the
  // configuration registers and the output register.
  pdwq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .status (status),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

endmodule

FILE: hdl/pdwq_ctrl.sv
`timescale 1ns / 1ps
module pdwq_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pdwq_pkg::dp_status_t status,
  output pdwq_pkg::ctrl_cmd_t  cmd
);
  import pdwq_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_INIT = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0] state_r, state_nxt;
  init_step_t step_r, step_nxt;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    cmd.in_ready  = 1'b0;
    cmd.commit    = 1'b0;
    cmd.init_wr   = 1'b0;
    cmd.init_step = step_r;
    case (state_r)
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (status.in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status.is_init) begin
          state_nxt = ST_INIT;
          step_nxt  = '0;
        end else if (status.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_INIT: begin
        cmd.init_wr = 1'b1;
        step_nxt    = step_r + 3'd1;
        if (step_r == INIT_LAST) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // The init writer never walks past the last command of the sequence.
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_INIT |-> step_r <= INIT_LAST)
    else $error("init step beyond sequence");

  // Every init pass leads straight into the final commit state.
  a_init_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_INIT && step_r == INIT_LAST |=> state_r == ST_FIN)
    else $error("init sequence did not finish");

  // A commit only ever happens with the output slot free.
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> status.out_free)
    else $error("commit with output slot occupied");

endmodule

FILE: hdl/pdwq_dp.sv
`timescale 1ns / 1ps
module pdwq_dp #(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pdwq_pkg::ctrl_cmd_t  cmd,
  output pdwq_pkg::dp_status_t status,
  pdwq_in_if.sink              in_ch,
  pdwq_out_if.source           out_ch,
  pdwq_cfg_if.sink             cfg_ch
);
  import pdwq_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [8:0]    mem [QUEUE_DEPTH];
  logic [8:0]    rd_data_r;
  func_t         func_r;
  byte_t         byte_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] rp_r, rp_nxt;
  logic          drain_r, drain_nxt;
  byte_t         wait_r, wait_nxt;
  byte_t         dgap_r, cgap_r, pwait_r;
  out_res_t      res_r, res_nxt;
  logic          out_valid_r;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [8:0]    mem_wdata;
  logic          put_ok;
  logic          is_put;
  logic [CW-1:0] rp_inc;
  logic          capture;

  assign capture         = in_ch.valid && cmd.in_ready;
  assign in_ch.ready     = cmd.in_ready;
  assign status.in_valid = in_ch.valid;
  assign status.is_init  = (func_r == FUNC_INIT);
  assign status.out_free = !out_valid_r || out_ch.ready;

  assign is_put = (func_r == FUNC_DATA) || (func_r == FUNC_COMMAND);
  assign put_ok = !drain_r && (count_r < CW'(QUEUE_DEPTH));
  assign rp_inc = CW'(rp_r) + CW'(1);

  always_comb begin
    count_nxt = count_r;
    rp_nxt    = rp_r;
    drain_nxt = drain_r;
    wait_nxt  = wait_r;
    res_nxt   = '0;
    res_nxt.accepted = 1'b1;
    case (func_r)
      FUNC_DATA, FUNC_COMMAND: begin
        res_nxt.accepted = put_ok;
        if (put_ok) begin
          count_nxt = count_r + CW'(1);
        end
      end
      FUNC_START: begin
        rp_nxt    = '0;
        drain_nxt = 1'b1;
      end
      FUNC_TICK: begin
        if (wait_r != '0) begin
          wait_nxt = wait_r - 8'd1;
        end else if (drain_r) begin
          if (count_r != '0) begin
            res_nxt.bus_write       = 1'b1;
            res_nxt.bus_byte        = rd_data_r[7:0];
            res_nxt.register_select = rd_data_r[8];
            wait_nxt = rd_data_r[8] ? dgap_r : cgap_r;
            if (rp_inc >= count_r) begin
              count_nxt = '0;
              rp_nxt    = '0;
              drain_nxt = 1'b0;
            end else begin
              rp_nxt = rp_inc[AW-1:0];
            end
          end else begin
            rp_nxt    = '0;
            drain_nxt = 1'b0;
          end
        end
      end
      FUNC_INIT: begin
        wait_nxt  = pwait_r;
        count_nxt = CW'(INIT_LEN);
        rp_nxt    = '0;
        drain_nxt = 1'b1;
      end
      default: begin
      end
    endcase
    res_nxt.busy_res = drain_nxt;
  end

  // Single write port shared by puts and the init sequence.
  assign mem_we    = cmd.init_wr || (cmd.commit && is_put && put_ok);
  assign mem_waddr = cmd.init_wr ? AW'(cmd.init_step) : count_r[AW-1:0];
  assign mem_wdata = cmd.init_wr ? {1'b0, init_cmd(cmd.init_step)}
                                 : {(func_r == FUNC_DATA), byte_r};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[rp_r];
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      func_r <= in_ch.func;
      byte_r <= in_ch.entry_byte;
    end
    if (cmd.commit) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      rp_r        <= '0;
      drain_r     <= 1'b0;
      wait_r      <= '0;
      dgap_r      <= DATA_GAP_RESET;
      cgap_r      <= COMMAND_GAP_RESET;
      pwait_r     <= POWERUP_WAIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        count_r <= count_nxt;
        rp_r    <= rp_nxt;
        drain_r <= drain_nxt;
        wait_r  <= wait_nxt;
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          CFG_DATA_GAP:     dgap_r  <= cfg_ch.data;
          CFG_COMMAND_GAP:  cgap_r  <= cfg_ch.data;
          CFG_POWERUP_WAIT: pwait_r <= cfg_ch.data;
          default: begin
          end
        endcase
      end
    end
  end

  assign cfg_ch.ready           = 1'b1;
  assign out_ch.valid           = out_valid_r;
  assign out_ch.bus_write       = res_r.bus_write;
  assign out_ch.bus_byte        = res_r.bus_byte;
  assign out_ch.register_select = res_r.register_select;
  assign out_ch.accepted        = res_r.accepted;
  assign out_ch.busy_res        = res_r.busy_res;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("entry count beyond queue depth");

  // While draining a non-empty queue the read pointer stays inside it.
  a_rp_inside: assert property (@(posedge clk) disable iff (!rst_n)
    drain_r && count_r != '0 |-> CW'(rp_r) < count_r)
    else $error("read position past entry count");

  a_rp_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !drain_r |-> rp_r == '0)
    else $error("read position left over while idle");

  // Only a put can come back rejected.
  a_reject_put: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && !res_nxt.accepted |-> is_put)
    else $error("rejection on a non-put item");

endmodule
